### hw/rtl/u8sd_pkg.sv
// types, constants and lead byte decode shared by the utf-8 stream decoder
package u8sd_pkg;

   localparam int CpWidth = 21;

   // result queue entries, a power of two of at least two
   localparam int QueueDepth = 4;

   localparam logic [CpWidth-1:0] CpReplacement = 21'h00FFFD;
   localparam logic [CpWidth-1:0] CpMax         = 21'h10FFFF;
   localparam logic [CpWidth-1:0] CpSurrLo      = 21'h00D800;
   localparam logic [CpWidth-1:0] CpSurrHi      = 21'h00DFFF;
   localparam logic [CpWidth-1:0] CpMin2        = 21'h000080;
   localparam logic [CpWidth-1:0] CpMax2        = 21'h0007FF;
   localparam logic [CpWidth-1:0] CpMin3        = 21'h000800;
   localparam logic [CpWidth-1:0] CpMax3        = 21'h00FFFF;
   localparam logic [CpWidth-1:0] CpMin4        = 21'h010000;

   localparam logic [2:0] Len2 = 3'd2;
   localparam logic [2:0] Len3 = 3'd3;
   localparam logic [2:0] Len4 = 3'd4;

   typedef struct packed {
      logic               in_sequence;
      logic [2:0]         bytes_remaining;
      logic [2:0]         sequence_length;
      logic [CpWidth-1:0] partial_value;
   } dec_state_type;

   typedef struct packed {
      logic               has_result;
      logic [CpWidth-1:0] code_point;
      dec_state_type      next_state;
   } lead_result_type;

   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               last_of_run;
   } rsp_entry_type;

   localparam dec_state_type StateIdle = '{
      in_sequence: 1'b0, bytes_remaining: 3'd0, sequence_length: 3'd0,
      partial_value: '0};

   // decode a byte seen while no sequence is open
   function automatic lead_result_type lead_byte(input logic [7:0] b);
      lead_result_type r;
      r.has_result = 1'b0;
      r.code_point = CpReplacement;
      r.next_state = StateIdle;
      if (b[7] == 1'b0) begin
         r.has_result = 1'b1;
         r.code_point = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
         r.next_state = '{1'b1, 3'd1, 3'd2, {10'd0, b[4:0], 6'd0}};
      end else if (b[7:4] == 4'b1110) begin
         r.next_state = '{1'b1, 3'd2, 3'd3, {5'd0, b[3:0], 12'd0}};
      end else if (b[7:3] == 5'b11110) begin
         r.next_state = '{1'b1, 3'd3, 3'd4, {b[2:0], 18'd0}};
      end else if (b[7:2] == 6'b111110) begin
         r.next_state = '{1'b1, 3'd4, 3'd5, {CpWidth{1'b0}}};
      end else if (b[7:1] == 7'b1111110) begin
         r.next_state = '{1'b1, 3'd5, 3'd6, {CpWidth{1'b0}}};
      end else begin
         r.has_result = 1'b1;
      end
      return r;
   endfunction

   // range, surrogate and length check of a completed sequence
   function automatic logic value_ok(input logic [CpWidth-1:0] v, input logic [2:0] len);
      logic ok;
      ok = 1'b0;
      case (len)
         Len2: ok = (v >= CpMin2) && (v <= CpMax2);
         Len3: ok = (v >= CpMin3) && (v <= CpMax3) && !((v >= CpSurrLo) && (v <= CpSurrHi));
         Len4: ok = (v >= CpMin4) && (v <= CpMax);
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

### hw/rtl/utf8_stream_decoder_top.sv
// utf-8 stream decoder top level: byte decode, sequence state and result queue
//
//   channel  direction  fields
//   req      in         data_byte[7:0], end_of_input
//   rsp      out        code_point[20:0], last_of_run
//
// one item is decoded in the cycle it is accepted; up to two results enter a
// four-entry result queue and leave one per cycle while rsp_ready is high.
// req_ready is high while the queue has room for two results, so items are
// taken every cycle while rsp drains one result a cycle and no item gives two.
// synchronous reset empties the queue and closes any open sequence.
module utf8_stream_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_code_point,
   output logic        rsp_last_of_run
);

   localparam int PtrWidth = (u8sd_pkg::QueueDepth > 1) ? $clog2(u8sd_pkg::QueueDepth) : 1;
   localparam int CntWidth = $clog2(u8sd_pkg::QueueDepth + 1);
   localparam logic [CntWidth-1:0] RoomLimit = CntWidth'(u8sd_pkg::QueueDepth - 2);

   u8sd_pkg::dec_state_type state_ff, state_in;

   u8sd_pkg::rsp_entry_type queue_ff [u8sd_pkg::QueueDepth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;

   logic                    req_fire;
   logic                    rsp_fire;
   logic [1:0]              push_n;
   u8sd_pkg::rsp_entry_type push0;
   u8sd_pkg::rsp_entry_type push1;
   u8sd_pkg::lead_result_type lead;
   logic [2:0]              rem_dec;
   logic [20:0]             add_bits;
   logic [20:0]             merged;
   logic [PtrWidth-1:0]     wr_ptr_next;

   assign req_ready = (count_ff <= RoomLimit);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_fire  = rsp_valid && rsp_ready;

   assign rsp_code_point  = queue_ff[rd_ptr_ff].code_point;
   assign rsp_last_of_run = queue_ff[rd_ptr_ff].last_of_run;

   // decode of the incoming item against the open sequence
   always_comb begin
      lead     = u8sd_pkg::lead_byte(req_data_byte);
      rem_dec  = state_ff.bytes_remaining - 3'd1;
      case (rem_dec[1:0])
         2'd0:    add_bits = {15'd0, req_data_byte[5:0]};
         2'd1:    add_bits = {9'd0, req_data_byte[5:0], 6'd0};
         2'd2:    add_bits = {3'd0, req_data_byte[5:0], 12'd0};
         2'd3:    add_bits = {req_data_byte[2:0], 18'd0};
         default: add_bits = '0;
      endcase
      merged = state_ff.partial_value;
      if (state_ff.sequence_length <= 3'd4) begin
         merged = state_ff.partial_value | add_bits;
      end

      state_in = state_ff;
      push_n   = 2'd0;
      push0    = '{code_point: u8sd_pkg::CpReplacement, last_of_run: 1'b1};
      push1    = '{code_point: lead.code_point, last_of_run: 1'b1};

      if (req_fire) begin
         if (req_end_of_input) begin
            if (state_ff.in_sequence) begin
               state_in = u8sd_pkg::StateIdle;
               push_n   = 2'd1;
            end
         end else if (!state_ff.in_sequence) begin
            state_in = lead.next_state;
            if (lead.has_result) begin
               push_n           = 2'd1;
               push0.code_point = lead.code_point;
            end
         end else if (req_data_byte[7:6] == 2'b10) begin
            state_in.bytes_remaining = rem_dec;
            state_in.partial_value   = merged;
            if (rem_dec == 3'd0) begin
               state_in = u8sd_pkg::StateIdle;
               push_n   = 2'd1;
               if (u8sd_pkg::value_ok(merged, state_ff.sequence_length)) begin
                  push0.code_point = merged;
               end
            end
         end else begin
            // interrupted sequence, then the byte starts over
            state_in = lead.next_state;
            if (lead.has_result) begin
               push_n            = 2'd2;
               push0.last_of_run = 1'b0;
            end else begin
               push_n = 2'd1;
            end
         end
      end
   end

   always_comb begin
      wr_ptr_next = wr_ptr_ff + PtrWidth'(1);
      wr_ptr_in   = wr_ptr_ff + PtrWidth'(push_n);
      rd_ptr_in   = rd_ptr_ff + PtrWidth'(rsp_fire);
      count_in    = count_ff + CntWidth'(push_n) - CntWidth'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= u8sd_pkg::StateIdle;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_next] <= push1;
      end
   end

endmodule
